// File: rtl/gnss_ubx_nmea_framer_top_macros.svh
// Assertion macros for the framer.
// Define ASSERT_OFF to compile the assertions out.
`ifndef GNSS_UBX_NMEA_FRAMER_TOP_MACROS_SVH
`define GNSS_UBX_NMEA_FRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, quiet during reset
`define GUNF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define GUNF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`else

`define GUNF_ASSERT_NOW(lbl, ante, cons)
`define GUNF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/gunf_pkg.sv
package gunf_pkg;

	// Longest body, the truncation point is LINE_MAX-1 stored bytes
	localparam int LINE_MAX = 512;
	localparam int CNT_W    = $clog2(LINE_MAX);
	localparam int LEN_W    = 16;
	localparam int CMP_W    = LEN_W + 1;

	localparam logic [CNT_W-1:0] TRUNC_AT = CNT_W'(LINE_MAX - 2);

	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UBX_SYNC_FIRST  = 3'd0,
		CFG_UBX_SYNC_SECOND = 3'd1,
		CFG_NMEA_START      = 3'd2,
		CFG_NMEA_SECOND_A   = 3'd3,
		CFG_NMEA_SECOND_B   = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] RST_UBX_SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] RST_UBX_SYNC_SECOND = 8'h62;
	localparam logic [7:0] RST_NMEA_START      = 8'h24;
	localparam logic [7:0] RST_NMEA_SECOND_A   = 8'h47;
	localparam logic [7:0] RST_NMEA_SECOND_B   = 8'h50;

	typedef struct packed {
		logic [7:0] ubx_sync_first;
		logic [7:0] ubx_sync_second;
		logic [7:0] nmea_start;
		logic [7:0] nmea_second_a;
		logic [7:0] nmea_second_b;
	} cfg_t;

	// Frame kinds
	localparam logic KIND_UBX  = 1'b0;
	localparam logic KIND_NMEA = 1'b1;

	// Parser phases, one-hot
	typedef enum logic [4:0] {
		PH_HUNT        = 5'b00001,
		PH_UBX_SYNC2   = 5'b00010,
		PH_NMEA_SECOND = 5'b00100,
		PH_NMEA_THIRD  = 5'b01000,
		PH_BODY        = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       frame_kind;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_header;
		logic       last;
		logic       truncated;
	} res_t;

endpackage

// File: rtl/gunf_if.sv
// Raw byte channel
interface gunf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Framed result channel
interface gunf_frame_if;
	logic       valid;
	logic       ready;
	logic       frame_kind;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_header;
	logic       last;
	logic       truncated;

	modport source (output valid, output frame_kind, output data_byte, output has_byte,
		output is_header, output last, output truncated, input ready);
	modport sink (input valid, input frame_kind, input data_byte, input has_byte,
		input is_header, input last, input truncated, output ready);
endinterface

// File: rtl/gunf_parser.sv
module gunf_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    c,
	input  gunf_pkg::cfg_t cfg,
	output logic          emit,
	output gunf_pkg::res_t res
);
	import gunf_pkg::*;

	phase_t           phase_q, phase_n;
	logic             kind_q, kind_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             cr_q, cr_n;
	logic             lst, trn;

	// Next state and result for the byte in hand
	always_comb begin
		phase_n = phase_q;
		kind_n  = kind_q;
		count_n = count_q;
		len_n   = len_q;
		cr_n    = cr_q;
		emit    = 1'b0;
		lst     = 1'b0;
		trn     = 1'b0;
		res     = '{frame_kind: kind_q, data_byte: c, has_byte: 1'b1,
			is_header: 1'b1, last: 1'b0, truncated: 1'b0};
		unique case (phase_q)
			PH_HUNT: begin
				if (c == cfg.ubx_sync_first) begin
					phase_n = PH_UBX_SYNC2;
				end else if (c == cfg.nmea_start) begin
					phase_n = PH_NMEA_SECOND;
				end
			end
			PH_UBX_SYNC2: begin
				if (c != cfg.ubx_sync_second) begin
					phase_n = PH_HUNT;
				end else begin
					kind_n         = KIND_UBX;
					count_n        = '0;
					len_n          = '0;
					cr_n           = 1'b0;
					phase_n        = PH_BODY;
					emit           = 1'b1;
					res.frame_kind = KIND_UBX;
				end
			end
			PH_NMEA_SECOND: begin
				if (c != cfg.nmea_second_a && c != cfg.nmea_second_b) begin
					phase_n = PH_HUNT;
				end else begin
					kind_n         = KIND_NMEA;
					count_n        = '0;
					len_n          = '0;
					cr_n           = 1'b0;
					phase_n        = PH_NMEA_THIRD;
					emit           = 1'b1;
					res.frame_kind = KIND_NMEA;
				end
			end
			PH_NMEA_THIRD: begin
				phase_n = PH_BODY;
				emit    = 1'b1;
			end
			PH_BODY: begin
				res.is_header = 1'b0;
				if (kind_q == KIND_NMEA && c == CR_BYTE) begin
					// hold the CR, nothing goes out
					cr_n = 1'b1;
				end else if (kind_q == KIND_NMEA && c == LF_BYTE && cr_q) begin
					// end marker, close the sentence
					emit          = 1'b1;
					res.data_byte = 8'h00;
					res.has_byte  = 1'b0;
					res.last      = 1'b1;
					phase_n       = PH_HUNT;
					count_n       = '0;
					len_n         = '0;
					cr_n          = 1'b0;
				end else begin
					cr_n = 1'b0;
					if (kind_q == KIND_UBX) begin
						// capture the little-endian length
						if (count_q == CNT_W'(2)) begin
							len_n = {len_q[LEN_W-1:8], c};
						end else if (count_q == CNT_W'(3)) begin
							len_n = {c, len_q[7:0]};
						end
						if (count_q >= CNT_W'(5) &&
							CMP_W'(count_q) == CMP_W'(len_n) + CMP_W'(5)) begin
							lst = 1'b1;
						end
					end
					if (!lst && count_q >= TRUNC_AT) begin
						lst = 1'b1;
						trn = 1'b1;
					end
					count_n       = count_q + CNT_W'(1);
					emit          = 1'b1;
					res.last      = lst;
					res.truncated = trn;
					if (lst) begin
						phase_n = PH_HUNT;
						count_n = '0;
						len_n   = '0;
						cr_n    = 1'b0;
					end
				end
			end
			default: begin
				phase_n = PH_HUNT;
				count_n = '0;
				len_n   = '0;
				cr_n    = 1'b0;
			end
		endcase
	end

	// Advance the state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			kind_q  <= KIND_UBX;
			count_q <= '0;
			len_q   <= '0;
			cr_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			count_q <= count_n;
			len_q   <= len_n;
			cr_q    <= cr_n;
		end
	end

endmodule

// File: rtl/gnss_ubx_nmea_framer_top.sv
// Channel | Dir | Payload                                              | Beat
// rx      | in  | rx_byte[7:0]                                         | valid & ready
// frm     | out | frame_kind, data_byte[7:0], has_byte, is_header,     | valid & ready
//         |     | last, truncated                                      |
// cfg     | in  | cfg_idx[2:0], cfg_wdata[7:0]                         | cfg_we
//
// One byte per cycle sustained while the output is not stalled; a taken byte passes
// through the input register, then the parser, and its result into the result register.
// Reset restores the default sync bytes and sends the parser hunting for a frame.
// A stalled output holds its result; the input register keeps taking bytes for as
// long as the output register can be refilled in the same cycle.
module gnss_ubx_nmea_framer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	gunf_byte_if.sink                     rx,
	gunf_frame_if.source                  frm,
	input  logic                          cfg_we,
	input  logic [gunf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                    cfg_wdata
);
	import gunf_pkg::*;

	`include "gnss_ubx_nmea_framer_top_macros.svh"

	cfg_t       cfg_q;
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       v_s2;
	res_t       res_s2;
	logic       proc_fire;
	logic       emit;
	res_t       res;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ubx_sync_first: RST_UBX_SYNC_FIRST,
				ubx_sync_second: RST_UBX_SYNC_SECOND,
				nmea_start: RST_NMEA_START,
				nmea_second_a: RST_NMEA_SECOND_A,
				nmea_second_b: RST_NMEA_SECOND_B};
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_UBX_SYNC_FIRST:  cfg_q.ubx_sync_first  <= cfg_wdata;
				CFG_UBX_SYNC_SECOND: cfg_q.ubx_sync_second <= cfg_wdata;
				CFG_NMEA_START:      cfg_q.nmea_start      <= cfg_wdata;
				CFG_NMEA_SECOND_A:   cfg_q.nmea_second_a   <= cfg_wdata;
				CFG_NMEA_SECOND_B:   cfg_q.nmea_second_b   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Process the held byte when the output register is free or draining
	assign proc_fire = v_s1 && (!v_s2 || frm.ready);
	assign rx.ready  = !v_s1 || proc_fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	gunf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc_fire),
		.c      (byte_s1),
		.cfg    (cfg_q),
		.emit   (emit),
		.res    (res)
	);

	// Result register: load on a processed beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (proc_fire) begin
			v_s2 <= emit;
		end else if (frm.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire) begin
			res_s2 <= res;
		end
	end

	assign frm.valid      = v_s2;
	assign frm.frame_kind = res_s2.frame_kind;
	assign frm.data_byte  = res_s2.data_byte;
	assign frm.has_byte   = res_s2.has_byte;
	assign frm.is_header  = res_s2.is_header;
	assign frm.last       = res_s2.last;
	assign frm.truncated  = res_s2.truncated;

	// An end marker is an NMEA close with no byte
	`GUNF_ASSERT_NOW(a_marker_shape, v_s2 && !res_s2.has_byte,
		res_s2.frame_kind == KIND_NMEA && res_s2.last && res_s2.data_byte == 8'h00)
	// Header beats never close a frame
	`GUNF_ASSERT_NOW(a_header_open, v_s2 && res_s2.is_header, !res_s2.last && !res_s2.truncated)
	// Truncation only on a closing beat
	`GUNF_ASSERT_NOW(a_trunc_last, v_s2 && res_s2.truncated, res_s2.last)
	// A held input byte is not lost while the output stalls
	`GUNF_ASSERT_NEXT(a_s1_hold, v_s1 && !proc_fire, v_s1 && $stable(byte_s1))

endmodule
